// ----- hdl/msc_pkg.sv -----
package msc_pkg;

  localparam int unsigned FailureLimit = 10;
  localparam int CntW = 4;
  localparam int FieldW = 21;
  localparam int DivSteps = 48;
  localparam int DivCntW = 6;

  localparam logic [1:0] RegTrimXy   = 2'd0;
  localparam logic [1:0] RegTrimZ12  = 2'd1;
  localparam logic [1:0] RegTrimZ34  = 2'd2;
  localparam logic [1:0] RegTrimXyz1 = 2'd3;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [48:0] num;
    logic signed [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [48:0] quo;
  } div_rsp_t;

  // Clamp a wide signed value to the signed 21-bit output range.
  function automatic logic signed [FieldW-1:0] sat_field(input logic signed [63:0] v);
    logic signed [FieldW-1:0] r;
    if (v > 64'sd1048575) begin
      r = 21'sd1048575;
    end else if (v < -64'sd1048576) begin
      r = -21'sd1048576;
    end else begin
      r = v[FieldW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/msc_in_if.sv -----
interface msc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_lsb;
  logic [7:0] x_msb;
  logic [7:0] y_lsb;
  logic [7:0] y_msb;
  logic [7:0] z_lsb;
  logic [7:0] z_msb;
  logic [7:0] hall_lsb;
  logic [7:0] hall_msb;
  logic [7:0] status_byte;
  logic       transfer_ok;

  modport source(output valid, x_lsb, x_msb, y_lsb, y_msb, z_lsb, z_msb, hall_lsb,
                 hall_msb, status_byte, transfer_ok, input ready);
  modport sink(input valid, x_lsb, x_msb, y_lsb, y_msb, z_lsb, z_msb, hall_lsb,
               hall_msb, status_byte, transfer_ok, output ready);
endinterface

// ----- hdl/msc_out_if.sv -----
interface msc_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] field_x;
  logic signed [20:0] field_y;
  logic signed [20:0] field_z;
  logic               sample_valid;
  logic               overflow_seen;
  logic               reset_request;

  modport source(output valid, field_x, field_y, field_z, sample_valid, overflow_seen,
                 reset_request, input ready);
  modport sink(input valid, field_x, field_y, field_z, sample_valid, overflow_seen,
               reset_request, output ready);
endinterface

// ----- hdl/msc_cfg_if.sv -----
interface msc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [47:0] data;

  modport source(output valid, idx, data, input ready);
  modport sink(input valid, idx, data, output ready);
endinterface

// ----- hdl/msc_mul.sv -----
// Shift-and-add signed multiplier, one bit of b per cycle; stops once the
// remaining bits of b are zero.
module msc_mul (
  input  logic              clk,
  input  logic              rst,
  input  msc_pkg::mul_req_t req,
  output msc_pkg::mul_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic        neg;
  logic [63:0] acc;
  logic [63:0] ash;
  logic [31:0] bsh;
  logic [63:0] amag;
  logic [32:0] bmag;

  assign amag = req.a[63] ? 64'(-req.a) : 64'(req.a);
  assign bmag = req.b[32] ? 33'(-req.b) : 33'(req.b);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        acc  <= '0;
        ash  <= amag;
        bsh  <= bmag[31:0];
        neg  <= req.a[63] ^ req.b[32];
      end else if (busy) begin
        if (bsh[0]) begin
          acc <= acc + ash;
        end
        ash <= ash << 1;
        bsh <= bsh >> 1;
        if (bsh[31:1] == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = neg ? -$signed(acc) : $signed(acc);

endmodule

// ----- hdl/msc_div.sv -----
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module msc_div (
  input  logic              clk,
  input  logic              rst,
  input  msc_pkg::div_req_t req,
  output msc_pkg::div_rsp_t rsp
);

  logic                        busy;
  logic                        done;
  logic                        neg;
  logic [msc_pkg::DivCntW-1:0] cnt;
  logic [31:0]                 rem;
  logic [47:0]                 quo;
  logic [31:0]                 dvs;
  logic [48:0]                 nmag;
  logic [32:0]                 dmag;
  logic [32:0]                 shifted;
  logic [32:0]                 diff;
  logic                        qbit;

  assign nmag    = req.num[48] ? 49'(-req.num) : 49'(req.num);
  assign dmag    = req.den[32] ? 33'(-req.den) : 33'(req.den);
  assign shifted = {rem, quo[47]};
  assign diff    = shifted - {1'b0, dvs};
  assign qbit    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= nmag[47:0];
        dvs  <= dmag[31:0];
        neg  <= req.num[48] ^ req.den[32];
      end else if (busy) begin
        rem <= qbit ? diff[31:0] : shifted[31:0];
        quo <= {quo[46:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == msc_pkg::DivCntW'(msc_pkg::DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

// ----- hdl/magnetometer_sample_compensation.sv -----
// Magnetometer sample compensation. Each transfer on samp carries one nine-byte
// sensor burst; exactly one result transfer on res follows, in order. A good
// sample (read succeeded, data ready, hall value nonzero, no overflow) is run
// through the trim compensation and published in microtesla times 16; any other
// sample yields zero fields with sample_valid low, and the failure counter may
// raise reset_request. The time a good sample takes from its transfer until its
// result is valid is set by the operand lengths: the work runs through one
// bit-serial multiplier (one multiplier bit per cycle, stopping early on short
// operands) and one bit-serial divider, used nine and two times in turn; the z
// division is skipped when z1, z2, the xyz1 trim or the z denominator is zero.
// A rejected sample goes from idle straight to the done state, which loads the
// output register. samp.ready is high only while the sequencer is idle; a finished
// result waits in the output register, so a new burst can be taken meanwhile, and
// the sequencer holds a further result until that register is free. Trim
// registers are written through cfg, which is always ready; the user must write
// them only while no sample is in flight, as the block does not enforce this.
module magnetometer_sample_compensation (
  input  logic      clk,
  input  logic      rst,
  msc_cfg_if.sink   cfg,
  msc_in_if.sink    samp,
  msc_out_if.source res
);

  typedef enum logic [3:0] {
    S_IDLE, S_TDIV, S_SQ, S_P1, S_P2, S_AX, S_MX, S_Z1, S_Z2, S_ZDIV, S_DONE
  } state_t;

  localparam logic signed [63:0] ALim = 64'sd562949953421312;

  state_t state;
  logic   issued;
  logic   axis;

  logic [47:0] trim_xy;
  logic [31:0] trim_z12;
  logic [31:0] trim_z34;
  logic [14:0] trim_xyz1;

  logic [msc_pkg::CntW-1:0] fail_count;
  logic [msc_pkg::CntW-1:0] fail_inc;
  logic                     fail_fire;

  // Sample registers and intermediate results.
  logic signed [12:0] x;
  logic signed [12:0] y;
  logic signed [14:0] z;
  logic [13:0]        r;
  logic               ok;
  logic               ovf;
  logic signed [30:0] v;
  logic signed [63:0] sq;
  logic signed [63:0] p;
  logic signed [63:0] a_reg;
  logic signed [48:0] zn;
  logic signed [32:0] zd;
  logic signed [20:0] fx;
  logic signed [20:0] fy;
  logic signed [20:0] fz;

  logic                     out_valid;
  logic signed [20:0]       out_x;
  logic signed [20:0]       out_y;
  logic signed [20:0]       out_z;
  logic                     out_ok;
  logic                     out_ovf;
  logic                     out_rst;

  msc_pkg::mul_req_t mul_req;
  msc_pkg::mul_rsp_t mul_rsp;
  msc_pkg::div_req_t div_req;
  msc_pkg::div_rsp_t div_rsp;

  // Incoming burst decode.
  logic signed [12:0] in_x;
  logic signed [12:0] in_y;
  logic signed [14:0] in_z;
  logic [13:0]        in_r;
  logic               in_good;
  logic               in_ovf;

  assign in_x    = {samp.x_msb, samp.x_lsb[7:3]};
  assign in_y    = {samp.y_msb, samp.y_lsb[7:3]};
  assign in_z    = {samp.z_msb, samp.z_lsb[7:1]};
  assign in_r    = {samp.hall_msb, samp.hall_lsb[7:2]};
  assign in_good = samp.transfer_ok && samp.hall_lsb[0] && (in_r != '0);
  assign in_ovf  = in_good && (samp.status_byte[6] || (in_x == -13'sd4096) ||
                   (in_y == -13'sd4096) || (in_z == -15'sd16384));

  // Trim fields.
  logic signed [7:0]  x1, y1, x2, y2, xy2, c1, c2;
  logic [7:0]         xy1;
  logic [15:0]        z1;
  logic signed [15:0] z2, z3, z4;

  assign x1  = trim_xy[7:0];
  assign y1  = trim_xy[15:8];
  assign x2  = trim_xy[23:16];
  assign y2  = trim_xy[31:24];
  assign xy1 = trim_xy[39:32];
  assign xy2 = trim_xy[47:40];
  assign z1  = trim_z12[15:0];
  assign z2  = trim_z12[31:16];
  assign z3  = trim_z34[15:0];
  assign z4  = trim_z34[31:16];
  assign c1  = axis ? y1 : x1;
  assign c2  = axis ? y2 : x2;

  assign samp.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  assign fail_inc  = fail_count + 1'b1;
  assign fail_fire = (fail_inc > msc_pkg::CntW'(msc_pkg::FailureLimit));

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    mul_req       = '0;
    div_req       = '0;
    mul_req.start = !issued && (state == S_SQ || state == S_P1 || state == S_P2 ||
                    state == S_AX || state == S_MX || state == S_Z1 || state == S_Z2);
    div_req.start = !issued && (state == S_TDIV || state == S_ZDIV);
    case (state)
      S_TDIV: begin
        div_req.num = $signed({20'd0, trim_xyz1, 14'd0});
        div_req.den = $signed({19'd0, r});
      end
      S_SQ: begin
        mul_req.a = 64'(v);
        mul_req.b = 33'(v);
      end
      S_P1: begin
        mul_req.a = sq >>> 14;
        mul_req.b = 33'(xy2);
      end
      S_P2: begin
        mul_req.a = 64'(v);
        mul_req.b = $signed({25'd0, xy1});
      end
      S_AX: begin
        mul_req.a = p;
        mul_req.b = 33'(c2) + 33'sd160;
      end
      S_MX: begin
        mul_req.a = a_reg;
        mul_req.b = axis ? 33'(y) : 33'(x);
      end
      S_Z1: begin
        mul_req.a = $signed({50'd0, r}) - $signed({49'd0, trim_xyz1});
        mul_req.b = 33'(z3);
      end
      S_Z2: begin
        mul_req.a = $signed({50'd0, r});
        mul_req.b = $signed({17'd0, z1});
      end
      S_ZDIV: begin
        div_req.num = zn;
        div_req.den = zd;
      end
      default: begin
      end
    endcase
  end

  // Result arithmetic on the unit outputs.
  logic signed [63:0] p_sum;
  logic signed [63:0] a_clamp;
  logic signed [63:0] xy_sum;
  logic signed [63:0] xy_adj;
  logic signed [20:0] xy_field;
  logic signed [63:0] zn_full;
  logic signed [63:0] zd_full;

  always_comb begin
    p_sum   = p + mul_rsp.prod + 64'sd4194304;
    a_clamp = mul_rsp.prod;
    if (mul_rsp.prod > ALim) begin
      a_clamp = ALim;
    end else if (mul_rsp.prod < -ALim) begin
      a_clamp = -ALim;
    end
    // Divide by 2^27 with truncation toward zero.
    xy_sum = mul_rsp.prod + (64'(c1) <<< 30);
    xy_adj = xy_sum[63] ? (xy_sum + 64'sd134217727) : xy_sum;
    xy_field = (trim_xyz1 == '0) ? 21'sd0 : msc_pkg::sat_field(xy_adj >>> 27);
    zn_full = ((64'(z) - 64'(z4)) <<< 17) - mul_rsp.prod;
    zd_full = mul_rsp.prod + (64'(z2) <<< 15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issued     <= 1'b0;
      out_valid  <= 1'b0;
      fail_count <= '0;
      trim_xy    <= '0;
      trim_z12   <= '0;
      trim_z34   <= '0;
      trim_xyz1  <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.idx)
          msc_pkg::RegTrimXy:   trim_xy   <= cfg.data;
          msc_pkg::RegTrimZ12:  trim_z12  <= cfg.data[31:0];
          msc_pkg::RegTrimZ34:  trim_z34  <= cfg.data[31:0];
          msc_pkg::RegTrimXyz1: trim_xyz1 <= cfg.data[14:0];
          default: begin
          end
        endcase
      end
      // The done state either loads the output register or waits on it.
      if (res.valid && res.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (mul_req.start || div_req.start) begin
        issued <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (samp.valid) begin
            x     <= in_x;
            y     <= in_y;
            z     <= in_z;
            r     <= in_r;
            ovf   <= in_ovf;
            ok    <= in_good && !in_ovf;
            axis  <= 1'b0;
            fx    <= '0;
            fy    <= '0;
            fz    <= '0;
            state <= (in_good && !in_ovf) ? S_TDIV : S_DONE;
          end
        end
        S_TDIV: begin
          if (div_rsp.done) begin
            v      <= 31'(div_rsp.quo - 49'sd16384);
            issued <= 1'b0;
            state  <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_rsp.done) begin
            sq     <= mul_rsp.prod;
            issued <= 1'b0;
            state  <= S_P1;
          end
        end
        S_P1: begin
          if (mul_rsp.done) begin
            p      <= mul_rsp.prod;
            issued <= 1'b0;
            state  <= S_P2;
          end
        end
        S_P2: begin
          if (mul_rsp.done) begin
            p      <= p_sum;
            issued <= 1'b0;
            state  <= S_AX;
          end
        end
        S_AX: begin
          if (mul_rsp.done) begin
            a_reg  <= a_clamp;
            issued <= 1'b0;
            state  <= S_MX;
          end
        end
        S_MX: begin
          if (mul_rsp.done) begin
            issued <= 1'b0;
            if (axis) begin
              fy    <= xy_field;
              state <= S_Z1;
            end else begin
              fx    <= xy_field;
              axis  <= 1'b1;
              state <= S_AX;
            end
          end
        end
        S_Z1: begin
          if (mul_rsp.done) begin
            zn     <= 49'(zn_full <<< 13);
            issued <= 1'b0;
            state  <= S_Z2;
          end
        end
        S_Z2: begin
          if (mul_rsp.done) begin
            zd     <= 33'(zd_full);
            issued <= 1'b0;
            // A zero trim or zero denominator leaves field_z at zero.
            if (zd_full == '0 || z1 == '0 || z2 == '0 || trim_xyz1 == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_ZDIV;
            end
          end
        end
        S_ZDIV: begin
          if (div_rsp.done) begin
            fz     <= msc_pkg::sat_field(64'(div_rsp.quo));
            issued <= 1'b0;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_x     <= fx;
            out_y     <= fy;
            out_z     <= fz;
            out_ok    <= ok;
            out_ovf   <= ovf;
            out_rst   <= 1'b0;
            if (ok) begin
              if (fail_count != '0) begin
                fail_count <= fail_count - 1'b1;
              end
            end else if (fail_fire) begin
              fail_count <= '0;
              out_rst    <= 1'b1;
            end else begin
              fail_count <= fail_inc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid         = out_valid;
  assign res.field_x       = out_x;
  assign res.field_y       = out_y;
  assign res.field_z       = out_z;
  assign res.sample_valid  = out_ok;
  assign res.overflow_seen = out_ovf;
  assign res.reset_request = out_rst;

  msc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  msc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // A burst transfer starts a job, so the sequencer must drop ready right after.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    (samp.valid && samp.ready) |=> !samp.ready)
    else $error("input ready stayed high after a transfer");

  // The failure counter never exceeds the limit: it returns to zero when a further failure would pass it.
  a_fail_bound: assert property (@(posedge clk) disable iff (rst)
    fail_count <= msc_pkg::CntW'(msc_pkg::FailureLimit))
    else $error("failure counter above limit");

  // A published sample never carries the overflow flag.
  a_pub_ovf: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.sample_valid) |-> !res.overflow_seen)
    else $error("published sample flagged as overflow");

  // The arithmetic units are only started by a compute state.
  a_unit_start: assert property (@(posedge clk) disable iff (rst)
    (mul_req.start || div_req.start) |-> (state != S_IDLE && state != S_DONE))
    else $error("arithmetic unit started outside a compute state");

endmodule
